// File: rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, constants and helpers of the path score block.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int SCORE_W = 16;
    localparam int SUM_W   = 34;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 16'hFFFF;
    localparam logic [14:0]        LOSS_FULL = 15'd25600;

    // ceil(2^26 / 25): exact floor(t / 25) for t below 2^21 as (t * LOSS_RECIP) >> 26
    localparam logic [21:0]        LOSS_RECIP = 22'd2684355;

    localparam logic [15:0] WEIGHT_RTT_RST  = 16'd26214;
    localparam logic [15:0] WEIGHT_BW_RST   = 16'd19661;
    localparam logic [15:0] WEIGHT_LOSS_RST = 16'd13107;
    localparam logic [15:0] WEIGHT_UTIL_RST = 16'd6554;
    localparam logic [23:0] BW_REF_RST      = 24'd125000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_RTT  = 3'd0,
        CFG_WEIGHT_BW   = 3'd1,
        CFG_WEIGHT_LOSS = 3'd2,
        CFG_WEIGHT_UTIL = 3'd3,
        CFG_BW_REF      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [SCORE_W-1:0] rtt;
        logic [SCORE_W-1:0] bw;
        logic [SCORE_W-1:0] loss;
        logic [SCORE_W-1:0] util;
    } parts_t;

    typedef parts_t weights_t;

    // floor(x / 65535) saturated to 65535, using x = a*65535 + (a + b)
    function automatic logic [SCORE_W-1:0] div_score(input logic [SUM_W-1:0] x);
        logic [17:0] a;
        logic [18:0] y;
        logic [16:0] z;
        logic [18:0] q;
        a = x[SUM_W-1:16];
        y = {1'b0, a} + {3'b000, x[15:0]};
        z = {14'd0, y[18:16]} + {1'b0, y[15:0]};
        q = {1'b0, a} + {16'd0, y[18:16]} + {18'd0, (z >= {1'b0, SCORE_ONE})};
        if (q > {3'b000, SCORE_ONE})
        begin
            return SCORE_ONE;
        end
        return q[SCORE_W-1:0];
    endfunction

endpackage

// File: rtl/mps_if.sv
// ----------------------------------------------------------------------------
// mps_if
// Valid/ready channels carrying path metrics in and scores out.
// ----------------------------------------------------------------------------
interface mps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] smoothed_rtt_us;
    logic [31:0] min_rtt_us;
    logic [39:0] bandwidth_bps;
    logic [15:0] loss_pct_q8;
    logic [31:0] scheduled_bytes;
    logic [31:0] inflight_bytes;
    logic [31:0] cwnd_bytes;

    modport source (
        output valid, smoothed_rtt_us, min_rtt_us, bandwidth_bps, loss_pct_q8,
               scheduled_bytes, inflight_bytes, cwnd_bytes,
        input  ready
    );
    modport sink (
        input  valid, smoothed_rtt_us, min_rtt_us, bandwidth_bps, loss_pct_q8,
               scheduled_bytes, inflight_bytes, cwnd_bytes,
        output ready
    );
endinterface

interface mps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] total_score;
    logic [15:0] rtt_part;
    logic [15:0] bandwidth_part;
    logic [15:0] loss_part;
    logic [15:0] utilization_part;

    modport source (
        output valid, total_score, rtt_part, bandwidth_part, loss_part, utilization_part,
        input  ready
    );
    modport sink (
        input  valid, total_score, rtt_part, bandwidth_part, loss_part, utilization_part,
        output ready
    );
endinterface

// File: rtl/mps_div_cell.sv
// ----------------------------------------------------------------------------
// mps_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module mps_div_cell #(
    parameter int DEN_W = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             v_i,
    input  logic [DEN_W-1:0] rem_i,
    input  logic [DEN_W-1:0] den_i,
    input  logic [15:0]      nlo_i,
    input  logic [15:0]      q_i,
    output logic             v_o,
    output logic [DEN_W-1:0] rem_o,
    output logic [DEN_W-1:0] den_o,
    output logic [15:0]      nlo_o,
    output logic [15:0]      q_o
);

    logic             v_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [15:0]      nlo_reg;
    logic [15:0]      q_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // shift in next numerator bit and try to subtract the divisor
    always_comb
    begin
        trial    = {rem_i, nlo_i[15]};
        diff     = trial - {1'b0, den_i};
        ge       = (trial >= {1'b0, den_i});
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_i;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_i;
            nlo_reg <= {nlo_i[14:0], 1'b0};
            q_reg   <= {q_i[14:0], ge};
        end
    end

    assign v_o   = v_reg;
    assign rem_o = rem_reg;
    assign den_o = den_reg;
    assign nlo_o = nlo_reg;
    assign q_o   = q_reg;

    // partial remainder always stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

endmodule

// File: rtl/mps_div_lane.sv
// ----------------------------------------------------------------------------
// mps_div_lane
// Chain of division cells computing floor(num * 65535 / den), num <= den.
// ----------------------------------------------------------------------------
module mps_div_lane import mps_pkg::*; #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 34
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               v_i,
    input  logic [NUM_W-1:0]   num_i,
    input  logic [DEN_W-1:0]   den_i,
    output logic               v_o,
    output logic [SCORE_W-1:0] q_o
);

    logic [NUM_W+15:0] prod;
    logic              v_w   [0:SCORE_W];
    logic [DEN_W-1:0]  rem_w [0:SCORE_W];
    logic [DEN_W-1:0]  den_w [0:SCORE_W];
    logic [15:0]       nlo_w [0:SCORE_W];
    logic [15:0]       q_w   [0:SCORE_W];

    // num * 65535 as shift and subtract; upper part seeds the remainder
    assign prod     = {num_i, 16'd0} - {16'd0, num_i};
    assign v_w[0]   = v_i;
    assign rem_w[0] = DEN_W'(prod[NUM_W+15:16]);
    assign den_w[0] = den_i;
    assign nlo_w[0] = prod[15:0];
    assign q_w[0]   = '0;

    // one cell per quotient bit
    for (genvar i = 0; i < SCORE_W; i++)
    begin : g_cell
        mps_div_cell #(.DEN_W(DEN_W)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .v_i   (v_w[i]),
            .rem_i (rem_w[i]),
            .den_i (den_w[i]),
            .nlo_i (nlo_w[i]),
            .q_i   (q_w[i]),
            .v_o   (v_w[i+1]),
            .rem_o (rem_w[i+1]),
            .den_o (den_w[i+1]),
            .nlo_o (nlo_w[i+1]),
            .q_o   (q_w[i+1])
        );
    end

    assign v_o = v_w[SCORE_W];
    assign q_o = q_w[SCORE_W];

endmodule

// File: rtl/mps_combine.sv
// ----------------------------------------------------------------------------
// mps_combine
// Weights the four component scores and sums the products.
// ----------------------------------------------------------------------------
module mps_combine import mps_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             v_i,
    input  parts_t           quot_i,
    input  weights_t         weights,
    output logic             v_o,
    output parts_t           parts_o,
    output logic [SUM_W-1:0] sum_o
);

    parts_t           parts;
    logic             v1_reg, v2_reg;
    parts_t           parts1_reg, parts2_reg;
    logic [31:0]      prod_rtt_reg, prod_bw_reg, prod_loss_reg, prod_util_reg;
    logic [SUM_W-1:0] sum_reg;

    // loss and utilization parts are the complement of their ratio
    always_comb
    begin
        parts.rtt  = quot_i.rtt;
        parts.bw   = quot_i.bw;
        parts.loss = SCORE_ONE - quot_i.loss;
        parts.util = SCORE_ONE - quot_i.util;
    end

    // valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_i;
            v2_reg <= v1_reg;
        end
    end

    // products then sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            parts1_reg    <= parts;
            prod_rtt_reg  <= parts.rtt * weights.rtt;
            prod_bw_reg   <= parts.bw * weights.bw;
            prod_loss_reg <= parts.loss * weights.loss;
            prod_util_reg <= parts.util * weights.util;
            parts2_reg    <= parts1_reg;
            sum_reg       <= SUM_W'(prod_rtt_reg) + SUM_W'(prod_bw_reg)
                           + SUM_W'(prod_loss_reg) + SUM_W'(prod_util_reg);
        end
    end

    assign v_o     = v2_reg;
    assign parts_o = parts2_reg;
    assign sum_o   = sum_reg;

endmodule

// File: rtl/multipath_path_score_top.sv
// ----------------------------------------------------------------------------
// multipath_path_score_top
// Path score from RTT, bandwidth, loss and window use, with weighted total.
// ----------------------------------------------------------------------------
// The block takes one transaction every cycle while the output is not stalled.
// The edge that accepts a transaction loads the ratio operands into the operand
// stage; the transaction then passes through the chains of division cells (one
// quotient bit per cell, three chains in parallel; the loss ratio, whose
// divisor is fixed, uses a reciprocal multiply and a delay line of the same
// length), then through the registers that weight and sum, and one output
// register holds the result. A stalled output freezes the whole pipeline and
// drops input ready.
module multipath_path_score_top import mps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mps_in_if.sink                in_ch,
    mps_out_if.source             out_ch
);

    weights_t    weights_reg;
    logic [23:0] bw_ref_reg;
    logic        pipe_en;

    logic [31:0] mrtt;
    logic [31:0] cwnd;
    logic [40:0] bw_ref;
    logic [32:0] used;
    logic        util_over;
    logic [14:0] loss_sat;
    logic [30:0] loss_x;

    logic        v0_reg;
    logic [32:0] rtt_num_reg;
    logic [33:0] rtt_den_reg;
    logic [39:0] bw_num_reg;
    logic [40:0] bw_den_reg;
    logic [20:0] loss_t_reg;
    logic [31:0] util_num_reg;
    logic [31:0] util_den_reg;

    logic [42:0]        loss_mul;
    logic [SCORE_W-1:0] loss_q_reg [0:SCORE_W-1];

    logic        v_rtt, v_bw, v_util;
    logic [SCORE_W-1:0] q_rtt, q_bw, q_util;
    parts_t      quot;
    logic        vc;
    parts_t      parts_c;
    logic [SUM_W-1:0] sum_c;

    logic        out_v_reg;
    logic [SCORE_W-1:0] score_reg;
    parts_t      parts_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.rtt  <= WEIGHT_RTT_RST;
            weights_reg.bw   <= WEIGHT_BW_RST;
            weights_reg.loss <= WEIGHT_LOSS_RST;
            weights_reg.util <= WEIGHT_UTIL_RST;
            bw_ref_reg       <= BW_REF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_RTT:  weights_reg.rtt  <= cfg_data[15:0];
                CFG_WEIGHT_BW:   weights_reg.bw   <= cfg_data[15:0];
                CFG_WEIGHT_LOSS: weights_reg.loss <= cfg_data[15:0];
                CFG_WEIGHT_UTIL: weights_reg.util <= cfg_data[15:0];
                CFG_BW_REF:      bw_ref_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished score is held
    assign pipe_en     = !out_v_reg || out_ch.ready;
    assign in_ch.ready = pipe_en;

    // ratio operands; zero minimum RTT, window and reference read as one
    always_comb
    begin
        mrtt      = (in_ch.min_rtt_us == 32'd0) ? 32'd1 : in_ch.min_rtt_us;
        cwnd      = (in_ch.cwnd_bytes == 32'd0) ? 32'd1 : in_ch.cwnd_bytes;
        bw_ref    = (bw_ref_reg == 24'd0) ? 41'd1 : {17'd0, bw_ref_reg};
        used      = {1'b0, in_ch.scheduled_bytes} + {1'b0, in_ch.inflight_bytes};
        util_over = (used >= {1'b0, cwnd});
        loss_sat  = (in_ch.loss_pct_q8 >= {1'b0, LOSS_FULL}) ? LOSS_FULL
                                                             : in_ch.loss_pct_q8[14:0];
        loss_x    = {loss_sat, 16'd0} - {16'd0, loss_sat};
    end

    // operand stage; overfull window divides den by den to give a zero part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v0_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            rtt_num_reg  <= {mrtt, 1'b0};
            rtt_den_reg  <= {1'b0, mrtt, 1'b0} + {2'b00, in_ch.smoothed_rtt_us};
            bw_num_reg   <= in_ch.bandwidth_bps;
            bw_den_reg   <= bw_ref + {1'b0, in_ch.bandwidth_bps};
            loss_t_reg   <= loss_x[30:10];
            util_num_reg <= util_over ? cwnd : used[31:0];
            util_den_reg <= cwnd;
        end
    end

    // division chains
    mps_div_lane #(.NUM_W(33), .DEN_W(34)) u_rtt (
        .clk (clk), .rst_n (rst_n), .en (pipe_en), .v_i (v0_reg),
        .num_i (rtt_num_reg), .den_i (rtt_den_reg), .v_o (v_rtt), .q_o (q_rtt)
    );

    mps_div_lane #(.NUM_W(40), .DEN_W(41)) u_bw (
        .clk (clk), .rst_n (rst_n), .en (pipe_en), .v_i (v0_reg),
        .num_i (bw_num_reg), .den_i (bw_den_reg), .v_o (v_bw), .q_o (q_bw)
    );

    mps_div_lane #(.NUM_W(32), .DEN_W(32)) u_util (
        .clk (clk), .rst_n (rst_n), .en (pipe_en), .v_i (v0_reg),
        .num_i (util_num_reg), .den_i (util_den_reg), .v_o (v_util), .q_o (q_util)
    );

    // loss ratio: loss*65535/1024 then divide by 25 with a reciprocal multiply
    assign loss_mul = {22'd0, loss_t_reg} * {21'd0, LOSS_RECIP};

    // delay line keeps the loss quotient in step with the division chains
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            loss_q_reg[0] <= loss_mul[41:26];
            for (int i = 1; i < SCORE_W; i++)
            begin
                loss_q_reg[i] <= loss_q_reg[i-1];
            end
        end
    end

    assign quot = '{rtt: q_rtt, bw: q_bw, loss: loss_q_reg[SCORE_W-1], util: q_util};

    // weighting and sum
    mps_combine u_combine (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .v_i     (v_rtt),
        .quot_i  (quot),
        .weights (weights_reg),
        .v_o     (vc),
        .parts_o (parts_c),
        .sum_o   (sum_c)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_v_reg <= vc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            score_reg <= div_score(sum_c);
            parts_reg <= parts_c;
        end
    end

    assign out_ch.valid            = out_v_reg;
    assign out_ch.total_score      = score_reg;
    assign out_ch.rtt_part         = parts_reg.rtt;
    assign out_ch.bandwidth_part   = parts_reg.bw;
    assign out_ch.loss_part        = parts_reg.loss;
    assign out_ch.utilization_part = parts_reg.util;

    // all division chains carry the same transaction
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (v_rtt == v_bw) && (v_rtt == v_util))
        else $error("division chains out of step");

    // a held output freezes the operand stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(v0_reg))
        else $error("pipeline moved during stall");

    // a summed transaction reaches the output register
    a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_en && vc) |=> out_v_reg)
        else $error("transaction lost before output");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the path score block against a cycle-free score predictor, with
// directed rows, random path metrics, random idling and register changes.
// ----------------------------------------------------------------------------
module testbench;
    import mps_pkg::*;

    typedef struct packed {
        logic [31:0] srtt;
        logic [31:0] mrtt;
        logic [39:0] bw;
        logic [15:0] loss;
        logic [31:0] sched;
        logic [31:0] infl;
        logic [31:0] cwnd;
    } metrics_t;

    typedef struct packed {
        logic [15:0] total;
        logic [15:0] rtt;
        logic [15:0] bw;
        logic [15:0] loss;
        logic [15:0] util;
    } scores_t;

    // directed row: metrics, plus a typed-in expectation where obvious
    typedef struct packed {
        metrics_t m;
        logic     known;
        scores_t  s;
    } row_t;

    // register index past the last register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mps_in_if  in_ch ();
    mps_out_if out_ch ();

    multipath_path_score_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // predictor copy of the registers
    logic [15:0] w_rtt, w_bw, w_loss, w_util;
    logic [23:0] bw_ref;

    scores_t expected_scores[$];
    int      errors;
    int      sent;
    int      received;
    bit      idle_enable;
    bit      busy_gap;

    always #4 clk = ~clk;

    function automatic logic [63:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
        if (den == 0)
        begin
            return 64'd0;
        end
        return (num * 64'd65535) / den;
    endfunction

    function automatic scores_t score_path(input metrics_t m);
        scores_t     r;
        logic [63:0] mr, cw, rf, rs, bs, ls, us, used, sum, tot;
        mr = (m.mrtt == 0) ? 64'd1 : {32'd0, m.mrtt};
        cw = (m.cwnd == 0) ? 64'd1 : {32'd0, m.cwnd};
        rf = (bw_ref == 0) ? 64'd1 : {40'd0, bw_ref};
        rs = q16_ratio(2 * mr, 2 * mr + m.srtt);
        bs = q16_ratio({24'd0, m.bw}, rf + m.bw);
        ls = (m.loss >= 16'd25600) ? 64'd0
                                   : 64'd65535 - q16_ratio({48'd0, m.loss}, 64'd25600);
        used = {32'd0, m.sched} + {32'd0, m.infl};
        us = (used >= cw) ? 64'd0 : 64'd65535 - q16_ratio(used, cw);
        sum = w_rtt * rs + w_bw * bs + w_loss * ls + w_util * us;
        tot = sum / 64'd65535;
        if (tot > 64'd65535)
        begin
            tot = 64'd65535;
        end
        r.total = tot[15:0];
        r.rtt   = rs[15:0];
        r.bw    = bs[15:0];
        r.loss  = ls[15:0];
        r.util  = us[15:0];
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WEIGHT_RTT:  w_rtt  = value[15:0];
            CFG_WEIGHT_BW:   w_bw   = value[15:0];
            CFG_WEIGHT_LOSS: w_loss = value[15:0];
            CFG_WEIGHT_UTIL: w_util = value[15:0];
            CFG_BW_REF:      bw_ref = value;
            default: ;
        endcase
    endtask

    task automatic set_weights(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] d,
                               input logic [23:0] rf);
        write_reg(CFG_WEIGHT_RTT, {8'd0, a});
        write_reg(CFG_WEIGHT_BW, {8'd0, b});
        write_reg(CFG_WEIGHT_LOSS, {8'd0, c});
        write_reg(CFG_WEIGHT_UTIL, {8'd0, d});
        write_reg(CFG_BW_REF, rf);
    endtask

    // stop sending, drain all expected scores, then let the pipeline settle
    task automatic drain_pipe();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
    endtask

    // present one transaction and hold it until accepted
    task automatic send_metrics(input metrics_t m, input bit known, input scores_t s);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.smoothed_rtt_us <= m.srtt;
        in_ch.min_rtt_us      <= m.mrtt;
        in_ch.bandwidth_bps   <= m.bw;
        in_ch.loss_pct_q8     <= m.loss;
        in_ch.scheduled_bytes <= m.sched;
        in_ch.inflight_bytes  <= m.infl;
        in_ch.cwnd_bytes      <= m.cwnd;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        expected_scores.push_back(known ? s : score_path(m));
        sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(2000);
            3: return $urandom_range(2000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic metrics_t rand_metrics();
        metrics_t m;
        m.srtt  = rand_word();
        m.mrtt  = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(200000);
        m.bw    = ($urandom_range(3) == 0) ? 40'({$urandom, $urandom}) : {8'd0, rand_word()};
        m.loss  = ($urandom_range(1) == 0) ? 16'($urandom_range(26000)) : 16'($urandom);
        m.sched = rand_word();
        m.infl  = rand_word();
        m.cwnd  = rand_word();
        if ($urandom_range(1) == 0)
        begin
            // realistic window use no larger than the window
            m.cwnd  = $urandom_range(32'h7FFF_FFFF);
            m.sched = $urandom_range(m.cwnd / 2);
            m.infl  = $urandom_range(m.cwnd / 2);
        end
        return m;
    endfunction

    // output side: random stall and compare
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= !(idle_enable && $urandom_range(99) < 33);
        end
    end

    always @(posedge clk)
    begin
        scores_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            received++;
            if (expected_scores.size() == 0)
            begin
                $display("%0t: unexpected transaction score %0d", $time, out_ch.total_score);
                errors++;
            end
            else
            begin
                want = expected_scores.pop_front();
                if (out_ch.total_score !== want.total || out_ch.rtt_part !== want.rtt
                    || out_ch.bandwidth_part !== want.bw || out_ch.loss_part !== want.loss
                    || out_ch.utilization_part !== want.util)
                begin
                    $display("%0t: expected %0d %0d %0d %0d %0d actual %0d %0d %0d %0d %0d",
                             $time, want.total, want.rtt, want.bw, want.loss, want.util,
                             out_ch.total_score, out_ch.rtt_part, out_ch.bandwidth_part,
                             out_ch.loss_part, out_ch.utilization_part);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        row_t     rows[$];
        row_t     r;
        scores_t  none;
        metrics_t m;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WEIGHT_RTT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.smoothed_rtt_us = '0;
        in_ch.min_rtt_us = '0;
        in_ch.bandwidth_bps = '0;
        in_ch.loss_pct_q8 = '0;
        in_ch.scheduled_bytes = '0;
        in_ch.inflight_bytes = '0;
        in_ch.cwnd_bytes = '0;
        errors = 0;
        sent = 0;
        received = 0;
        idle_enable = 1'b1;
        none = '0;
        w_rtt = WEIGHT_RTT_RST;
        w_bw = WEIGHT_BW_RST;
        w_loss = WEIGHT_LOSS_RST;
        w_util = WEIGHT_UTIL_RST;
        bw_ref = BW_REF_RST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, run with reset weights
        // all zero: min rtt and window read as one, rtt, loss and util parts 1.0
        rows.push_back('{m: '0, known: 1, s: '{16'd45875, 16'd65535, 0, 16'd65535,
                                               16'd65535}});
        // all ones: loss above full, window overfull
        rows.push_back('{m: '1, known: 0, s: none});
        // bandwidth zero, loss exactly full, used equals window
        rows.push_back('{m: '{100, 100, 0, 25600, 5, 5, 10}, known: 1,
                         s: '{16'd17476, 16'd43690, 0, 0, 0}});
        // bandwidth equals reference: half score
        rows.push_back('{m: '{0, 7, 125000, 0, 0, 0, 0}, known: 0, s: none});
        rows.push_back('{m: '{32'hFFFF_FFFF, 0, 40'hFF_FFFF_FFFF, 25599, 0, 0, 32'hFFFF_FFFF},
                         known: 0, s: none});
        rows.push_back('{m: '{1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF}, known: 0, s: none});
        rows.push_back('{m: '{30000, 20000, 1000000, 512, 1000, 3000, 20000}, known: 0,
                         s: none});
        rows.push_back('{m: '{32'hAAAA_AAAA, 32'h5555_5555, 40'hAA_AAAA_AAAA, 16'hAAAA,
                              32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
                         known: 0, s: none});
        rows.push_back('{m: '{32'h5555_5555, 32'hAAAA_AAAA, 40'h55_5555_5555, 16'h5555,
                              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
                         known: 0, s: none});
        foreach (rows[i])
        begin
            r = rows[i];
            send_metrics(r.m, r.known, r.s);
        end
        drain_pipe();

        // saturating weights, zero reference read as one
        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0);
        send_metrics('{0, 0, 0, 0, 0, 0, 2}, 1'b1, '{16'd65535, 16'd65535, 0, 16'd65535,
                                                     16'd65535});
        send_metrics('1, 1'b0, none);
        send_metrics('{10, 10, 40'd1, 0, 0, 0, 5}, 1'b0, none);
        drain_pipe();
        // out-of-range index: ignored
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_UNUSED;
        cfg_data <= '1;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_metrics('{0, 0, 0, 0, 0, 0, 2}, 1'b1, '{16'd65535, 16'd65535, 0, 16'd65535,
                                                     16'd65535});
        drain_pipe();

        // random phases under several weight settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_weights(16'd0, 16'd0, 16'd0, 16'd0, 24'd1);
                1: set_weights(WEIGHT_RTT_RST, WEIGHT_BW_RST, WEIGHT_LOSS_RST,
                               WEIGHT_UTIL_RST, 24'hFF_FFFF);
                default: set_weights(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 24'($urandom_range(24'hFF_FFFF)));
            endcase
            idle_enable = (ph != 3);
            for (int k = 0; k < 258; k++)
            begin
                m = rand_metrics();
                send_metrics(m, 1'b0, none);
                if (ph == 4 && k == 100)
                begin
                    // hold off until every score is back
                    drain_pipe();
                end
            end
            drain_pipe();
        end
        idle_enable = 1'b1;

        $display("covered %0d path transactions over eight register settings", sent);
        $display("including zero, saturated and overfull metric corners; %0d scores checked",
                 received);
        if (errors == 0 && expected_scores.size() == 0)
        begin
            $display("[multipath_path_score_top] OK");
        end
        else
        begin
            $display("[multipath_path_score_top] ERROR");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("[multipath_path_score_top] ERROR");
        $finish;
    end

endmodule
